[hw/rtl/svpwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg: shared types, constants and functions
// Fixed-point formats, queue sizing, sector codes and the sine generator
// used to build the angle lookup tables at elaboration.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // input angle index
  localparam int IndexW  = 8;
  localparam int TblSize = 1 << IndexW;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // configuration registers
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;
  localparam logic [15:0] PeriodReset = 16'd4200;
  localparam logic [14:0] AmpReset    = 15'd18350;

  // fixed-point constants
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam logic [16:0]     Sqrt3Q15  = 17'd56756;
  localparam logic [15:0]     OneQ15    = 16'd32768;
  localparam logic [15:0]     HalfQ15   = 16'd16384;

  // width of dwell and phase times before clamping
  localparam int TimeW = 21;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [TimeW-1:0] time_t;
  typedef logic [2:0] sector_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeriod    = 1'b0,
    RegAmplitude = 1'b1
  } reg_idx_t;

  localparam sector_t SecNone = 3'd0;
  localparam sector_t Sec1    = 3'd1;
  localparam sector_t Sec2    = 3'd2;
  localparam sector_t Sec3    = 3'd3;
  localparam sector_t Sec4    = 3'd4;
  localparam sector_t Sec5    = 3'd5;
  localparam sector_t Sec6    = 3'd6;

  typedef struct packed {
    sample_t sin_val;
    sample_t cos_val;
  } lut_t;

  typedef struct packed {
    logic [15:0] period_count;
    logic [14:0] amplitude;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Taylor series of sin through x^11, angle in Q2.30, each term truncated
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    return sum;
  endfunction

  // Q1.15 sine for a quadrant and an angle within that quadrant
  function automatic sample_t sine_value(input longint unsigned quad,
                                         input longint unsigned x);
    longint unsigned xr;
    longint unsigned v;
    sample_t         r;
    xr = ((quad & 64'd1) != 64'd0) ? (PiHalfQ30 - x) : x;
    v  = (sin_q30(xr) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    r = sample_t'(v[15:0]);
    return (quad >= 64'd2) ? -r : r;
  endfunction

  // map the three projection signs onto a voltage sector
  function automatic sector_t sector_of(input logic [2:0] code);
    sector_t s;
    unique case (code)
      3'b011:  s = Sec1;
      3'b001:  s = Sec2;
      3'b101:  s = Sec3;
      3'b100:  s = Sec4;
      3'b110:  s = Sec5;
      3'b010:  s = Sec6;
      default: s = SecNone;
    endcase
    return s;
  endfunction

  // limit a phase time to 0..1.0 in Q15
  function automatic logic [15:0] clamp_phase(input time_t p);
    logic [15:0] r;
    if (p < 0) begin
      r = 16'd0;
    end else if (p > $signed(TimeW'(OneQ15))) begin
      r = OneQ15;
    end else begin
      r = p[15:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/space_vector_pwm_duty_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_top: seven-segment space vector PWM duty generator
// Turns a rotor angle index into three centre-aligned timer compare values
// and the voltage sector.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  input     | in_valid / in_ready    | phase_index
//  result    | out_valid / out_ready  | compare_u, compare_v, compare_w, sector
//  config    | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One beat per clock is sustained in both directions while the result side
//  is not stalled. The input beat is written to the queue at its accepting
//  edge and then passes through the seven duty stages, the last of which is
//  the output register. Synchronous reset empties the queue and pipeline and
//  loads period 4200 and amplitude 18350. A stalled result side holds the
//  pipeline; input beats are taken until the four-entry queue fills, then
//  in_ready drops.
//
module space_vector_pwm_duty_top #(
  parameter int TABLE_POINTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [svpwm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [svpwm_pkg::CfgDataW-1:0]  cfg_data,
  // angle input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [svpwm_pkg::IndexW-1:0]    phase_index,
  // duty result
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     compare_u,
  output logic [15:0]                     compare_v,
  output logic [15:0]                     compare_w,
  output svpwm_pkg::sector_t              sector
);
  import svpwm_pkg::*;

  logic [15:0] period_count;
  logic [14:0] amplitude;
  cfg_t        cfg;
  q_stat_t     q_stat;
  logic        push;
  logic        pop;
  lut_t        push_data;
  lut_t        rd_data;

  // Configuration registers: the user must write them only while the block is idle (not
  // enforced by the block itself), so the pipeline reads them directly without a shadow copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= PeriodReset;
      amplitude    <= AmpReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        RegPeriod:    period_count <= cfg_data;
        RegAmplitude: amplitude    <= cfg_data[14:0];
      endcase
    end
  end

  assign cfg.period_count = period_count;
  assign cfg.amplitude    = amplitude;

  // Front: accept the beat and look up sine and cosine.
  svpwm_front #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .phase_index (phase_index),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  // Queue: decouple the input side from output stalls.
  svpwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .q_stat    (q_stat)
  );

  // Back: sector, dwell times, phase ordering and compare scaling.
  svpwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .q_data    (rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .compare_u (compare_u),
    .compare_v (compare_v),
    .compare_w (compare_w),
    .sector    (sector)
  );

  // An accepted beat always lands in the queue.
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  // Compare values never exceed the timer period.
  a_cmp_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> compare_u <= period_count && compare_v <= period_count &&
                  compare_w <= period_count)
    else $error("compare value above period");

  // Without a valid sector every phase sits at half period.
  a_no_sector: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector == SecNone |->
      compare_u == compare_v && compare_v == compare_w &&
      compare_u == (period_count >> 1))
    else $error("sector none gives unequal compares");

  // The queue never pops while empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

[hw/rtl/svpwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_front: input acceptance and angle lookup
// Takes one angle index per beat, looks up sine and cosine and pushes the
// pair into the queue.
// ----------------------------------------------------------------------------
module svpwm_front #(
  parameter int TABLE_POINTS = 256
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [svpwm_pkg::IndexW-1:0]  phase_index,
  input  svpwm_pkg::q_stat_t            q_stat,
  output logic                          push,
  output svpwm_pkg::lut_t               push_data
);
  import svpwm_pkg::*;

  sample_t sin_tbl [TblSize];
  sample_t cos_tbl [TblSize];

  // Fold the table wrap and the quarter-turn cosine offset into tables
  // addressed directly by the raw index.
  for (genvar g = 0; g < TblSize; g++) begin : g_tbl
    localparam longint unsigned SIdx  = 64'(g) % TABLE_POINTS;
    localparam longint unsigned CIdx  = (SIdx + TABLE_POINTS / 4) % TABLE_POINTS;
    localparam longint unsigned SQuad = ((SIdx * 4) / TABLE_POINTS) % 4;
    localparam longint unsigned SRem  = (SIdx * 4) % TABLE_POINTS;
    localparam longint unsigned SX    = SRem * PiHalfQ30 / TABLE_POINTS;
    localparam longint unsigned CQuad = ((CIdx * 4) / TABLE_POINTS) % 4;
    localparam longint unsigned CRem  = (CIdx * 4) % TABLE_POINTS;
    localparam longint unsigned CX    = CRem * PiHalfQ30 / TABLE_POINTS;
    assign sin_tbl[g] = sine_value(SQuad, SX);
    assign cos_tbl[g] = sine_value(CQuad, CX);
  end

  assign in_ready          = !q_stat.full;
  assign push              = in_valid && in_ready;
  assign push_data.sin_val = sin_tbl[phase_index];
  assign push_data.cos_val = cos_tbl[phase_index];

endmodule

[hw/rtl/svpwm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_queue: short first-in first-out queue
// Holds looked-up sine and cosine pairs between the front and the back.
// ----------------------------------------------------------------------------
module svpwm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  svpwm_pkg::lut_t    push_data,
  input  logic               pop,
  output svpwm_pkg::lut_t    rd_data,
  output svpwm_pkg::q_stat_t q_stat
);
  import svpwm_pkg::*;

  lut_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign q_stat.full  = (count == QueueCntW'(QueueDepth));
  assign q_stat.empty = (count == '0);
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      priority if (push && !pop) begin
        count <= count + QueueCntW'(1);
      end else if (pop && !push) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

endmodule

[hw/rtl/svpwm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_back: duty computation pipeline
// Seven registered stages from sine and cosine to the timer compare values,
// the last being the output register.
// ----------------------------------------------------------------------------
module svpwm_back (
  input  logic               clk,
  input  logic               rst,
  input  svpwm_pkg::cfg_t    cfg,
  input  svpwm_pkg::q_stat_t q_stat,
  input  svpwm_pkg::lut_t    q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        compare_u,
  output logic [15:0]        compare_v,
  output logic [15:0]        compare_w,
  output svpwm_pkg::sector_t sector
);
  import svpwm_pkg::*;

  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: amplitude scaling
  logic signed [15:0] amp_s;
  logic signed [31:0] prod_c, prod_s;
  sample_t            ubeta1, ualpha1;
  // stage 2: sqrt(3) * alpha
  logic signed [33:0] sa_prod;
  logic signed [17:0] sa2;
  sample_t            ubeta2;
  // stage 3: projections and sector
  logic signed [18:0] d2_c, d3_c;
  sample_t            u1_3;
  logic signed [18:0] d2_3, d3_3;
  sector_t            sec3;
  // stage 4: scaled projections
  logic signed [33:0] p1_prod;
  logic signed [36:0] p2_prod, p3_prod;
  logic signed [17:0] p1_4, p2_4, p3_4;
  sector_t            sec4;
  // stage 5: dwell times
  time_t              t1_c, t2_c, ta_sum;
  time_t              t1_5, t2_5, ta5;
  sector_t            sec5;
  // stage 6: phase times
  time_t              tb_c, tc_c, pu_c, pv_c, pw_c;
  logic [15:0]        ph_u, ph_v, ph_w;
  sector_t            sec6;
  // stage 7: compare values
  logic [31:0]        cmp_u, cmp_v, cmp_w;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= !q_stat.empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  assign amp_s   = $signed({1'b0, cfg.amplitude});
  assign prod_c  = amp_s * q_data.cos_val;
  assign prod_s  = -(amp_s * q_data.sin_val);
  assign sa_prod = ualpha1 * $signed({1'b0, Sqrt3Q15});
  assign d2_c    = 19'(sa2) - 19'(ubeta2);
  assign d3_c    = -(19'(sa2) + 19'(ubeta2));
  assign p1_prod = u1_3 * $signed({1'b0, Sqrt3Q15});
  assign p2_prod = d2_3 * $signed({1'b0, Sqrt3Q15});
  assign p3_prod = d3_3 * $signed({1'b0, Sqrt3Q15});

  // pick dwell times for the sector
  always_comb begin
    t1_c = '0;
    t2_c = '0;
    unique case (sec4)
      Sec1: begin t1_c = TimeW'(p2_4);  t2_c = TimeW'(p1_4);  end
      Sec2: begin t1_c = -TimeW'(p2_4); t2_c = -TimeW'(p3_4); end
      Sec3: begin t1_c = TimeW'(p1_4);  t2_c = TimeW'(p3_4);  end
      Sec4: begin t1_c = -TimeW'(p1_4); t2_c = -TimeW'(p2_4); end
      Sec5: begin t1_c = TimeW'(p3_4);  t2_c = TimeW'(p2_4);  end
      Sec6: begin t1_c = -TimeW'(p3_4); t2_c = -TimeW'(p1_4); end
      default: begin t1_c = '0; t2_c = '0; end
    endcase
  end

  assign ta_sum = $signed(TimeW'(OneQ15)) - t1_c - t2_c;
  assign tb_c   = ta5 + t1_5;
  assign tc_c   = tb_c + t2_5;

  // assign the ordered times to the phases
  always_comb begin
    unique case (sec5)
      Sec1: begin pu_c = ta5;  pv_c = tb_c; pw_c = tc_c; end
      Sec2: begin pu_c = tb_c; pv_c = ta5;  pw_c = tc_c; end
      Sec3: begin pu_c = tc_c; pv_c = ta5;  pw_c = tb_c; end
      Sec4: begin pu_c = tc_c; pv_c = tb_c; pw_c = ta5;  end
      Sec5: begin pu_c = tb_c; pv_c = tc_c; pw_c = ta5;  end
      Sec6: begin pu_c = ta5;  pv_c = tc_c; pw_c = tb_c; end
      default: begin
        pu_c = $signed(TimeW'(HalfQ15));
        pv_c = $signed(TimeW'(HalfQ15));
        pw_c = $signed(TimeW'(HalfQ15));
      end
    endcase
  end

  assign cmp_u = cfg.period_count * ph_u;
  assign cmp_v = cfg.period_count * ph_v;
  assign cmp_w = cfg.period_count * ph_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      ubeta1    <= prod_c[30:15];
      ualpha1   <= prod_s[30:15];
      ubeta2    <= ubeta1;
      sa2       <= sa_prod[32:15];
      u1_3      <= ubeta2;
      d2_3      <= d2_c;
      d3_3      <= d3_c;
      sec3      <= sector_of({d3_c > 0, d2_c > 0, ubeta2 > 0});
      p1_4      <= p1_prod[32:15];
      p2_4      <= p2_prod[33:16];
      p3_4      <= p3_prod[33:16];
      sec4      <= sec3;
      t1_5      <= t1_c;
      t2_5      <= t2_c;
      ta5       <= ta_sum >>> 1;
      sec5      <= sec4;
      ph_u      <= clamp_phase(pu_c);
      ph_v      <= clamp_phase(pv_c);
      ph_w      <= clamp_phase(pw_c);
      sec6      <= sec5;
      compare_u <= cmp_u[30:15];
      compare_v <= cmp_v[30:15];
      compare_w <= cmp_w[30:15];
      sector    <= sec6;
    end
  end

endmodule

[tb/sv/tb_space_vector_pwm_duty_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_duty_top: self-checking bench for the SVPWM duty block
// Feeds angle indices through a valid/ready driver and checks every result
// beat against a duty predictor with its own sine table and register copies.
// Period and amplitude are swept between drained phases. Both sides idle at
// random, and the result side is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_duty_top;
  import svpwm_pkg::*;

  localparam int     HoldCycles  = 150;     // long result-side hold-off
  localparam int     SettleTicks = 12;      // lets the pipeline run dry after the last result
  localparam int     PhaseItems  = 70;      // per half of a random phase
  localparam int     NumPhases   = 8;
  localparam int     MaxPrints   = 200;
  localparam longint Root3Q15    = 56756;   // sqrt(3) in Q15

  typedef struct packed {
    logic [15:0] cmp_u;
    logic [15:0] cmp_v;
    logic [15:0] cmp_w;
    sector_t     sec;
  } duty_t;

  // DUT ports: every input known from time zero
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  reg_idx_t    cfg_index   = RegPeriod;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  phase_index = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [15:0] compare_u;
  logic [15:0] compare_v;
  logic [15:0] compare_w;
  sector_t     sector;

  // predictor state: sine table and mirrored registers
  logic signed [15:0] sin_lut [TblSize];
  logic [15:0]        want_period;
  logic [14:0]        want_amp;

  // angles waiting to be driven, duty results waiting to arrive
  logic [7:0] angle_queue [$];
  duty_t      duty_due [$];
  duty_t      duty_head;

  // idling percentages and the hold-off handshake
  int unsigned send_gap  = 17;
  int unsigned recv_gap  = 55;
  int          hold_req  = 0;
  int          hold_ack  = 0;
  int          hold_left = 0;
  int          mismatches = 0;

  space_vector_pwm_duty_top #(
    .TABLE_POINTS(TblSize)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .phase_index(phase_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .compare_u  (compare_u),
    .compare_v  (compare_v),
    .compare_w  (compare_w),
    .sector     (sector)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sine table generation: quarter-wave angle in Q2.30, odd Taylor terms up
  // to x^11 with every term truncated, scaled to Q1.15 with half-up rounding.
  // --------------------------------------------------------------------------
  function automatic longint unsigned series_sin(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    int unsigned     denom [5];
    denom = '{6, 20, 42, 72, 110};
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 5; k++) begin
      term = ((term * x2) >> 30) / denom[k];
      if (k % 2 == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [15:0] rom_entry(input int i);
    longint unsigned f;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned v;
    logic signed [15:0] mag;
    f    = longint'(i) * 4;
    quad = (f / TblSize) & 64'd3;
    x    = (f % TblSize) * PiHalfQ30 / TblSize;
    if (quad[0]) begin
      x = PiHalfQ30 - x;
    end
    v = (series_sin(x) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    mag = $signed(v[15:0]);
    return (quad >= 64'd2) ? -mag : mag;
  endfunction

  // --------------------------------------------------------------------------
  // Duty predictor: alpha/beta from the table, sector from the projection
  // signs, dwell times, seven-segment ordering, clamp and period scaling.
  // Arithmetic right shifts on signed values give the floor everywhere.
  // --------------------------------------------------------------------------
  function automatic duty_t duty_of(input logic [7:0] idx);
    logic [7:0] cidx;
    logic [2:0] code;
    sector_t    sec;
    longint     amp, per, s, c, ubeta, ualpha, sa, u1, d2, d3;
    longint     p1, p2, p3, t1, t2, ta, tb, tc;
    longint     ph [3];
    duty_t      r;
    cidx   = idx + 8'd64;
    amp    = want_amp;
    per    = want_period;
    s      = sin_lut[idx];
    c      = sin_lut[cidx];
    ubeta  = (amp * c) >>> 15;
    ualpha = (-(amp * s)) >>> 15;
    sa     = (Root3Q15 * ualpha) >>> 15;
    u1     = ubeta;
    d2     = sa - ubeta;
    d3     = -(sa + ubeta);
    code   = {d3 > 0, d2 > 0, u1 > 0};
    case (code)
      3'b011:  sec = Sec1;
      3'b001:  sec = Sec2;
      3'b101:  sec = Sec3;
      3'b100:  sec = Sec4;
      3'b110:  sec = Sec5;
      3'b010:  sec = Sec6;
      default: sec = SecNone;
    endcase
    p1 = (Root3Q15 * u1) >>> 15;
    p2 = (Root3Q15 * d2) >>> 16;
    p3 = (Root3Q15 * d3) >>> 16;
    case (sec)
      Sec1:    begin t1 = p2;  t2 = p1;  end
      Sec2:    begin t1 = -p2; t2 = -p3; end
      Sec3:    begin t1 = p1;  t2 = p3;  end
      Sec4:    begin t1 = -p1; t2 = -p2; end
      Sec5:    begin t1 = p3;  t2 = p2;  end
      Sec6:    begin t1 = -p3; t2 = -p1; end
      default: begin t1 = 0;   t2 = 0;   end
    endcase
    ta = (32768 - t1 - t2) >>> 1;
    tb = ta + t1;
    tc = tb + t2;
    case (sec)
      Sec1:    ph = '{ta, tb, tc};
      Sec2:    ph = '{tb, ta, tc};
      Sec3:    ph = '{tc, ta, tb};
      Sec4:    ph = '{tc, tb, ta};
      Sec5:    ph = '{tb, tc, ta};
      Sec6:    ph = '{ta, tc, tb};
      default: ph = '{16384, 16384, 16384};
    endcase
    for (int k = 0; k < 3; k++) begin
      if (ph[k] < 0) begin
        ph[k] = 0;
      end else if (ph[k] > 32768) begin
        ph[k] = 32768;
      end
      ph[k] = (per * ph[k]) >>> 15;
    end
    r.cmp_u = ph[0][15:0];
    r.cmp_v = ph[1][15:0];
    r.cmp_w = ph[2][15:0];
    r.sec   = sec;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatches < MaxPrints) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    end
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Record the prediction for the beat taken at this edge, then
  // either hold the current beat or offer the next angle, unless idling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        duty_due.push_back(duty_of(phase_index));
      end
      if (!in_valid || in_ready) begin
        if (angle_queue.size() != 0 && $urandom_range(99) >= send_gap) begin
          in_valid    <= 1'b1;
          phase_index <= angle_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Compare each result beat with the oldest prediction, then
  // pick the next out_ready: low during a hold-off, otherwise random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (duty_due.size() == 0) begin
          flag_mismatch("result beat with nothing due, compare_u", compare_u, '0);
        end else begin
          duty_head = duty_due.pop_front();
          if (compare_u !== duty_head.cmp_u) begin
            flag_mismatch("compare_u", compare_u, duty_head.cmp_u);
          end
          if (compare_v !== duty_head.cmp_v) begin
            flag_mismatch("compare_v", compare_v, duty_head.cmp_v);
          end
          if (compare_w !== duty_head.cmp_w) begin
            flag_mismatch("compare_w", compare_w, duty_head.cmp_w);
          end
          if (sector !== duty_head.sec) begin
            flag_mismatch("sector", 16'(sector), 16'(duty_head.sec));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap);
    end
  end

  // Count the long hold-off here; a new request is a bump of hold_req.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Wait until every angle is driven and every result has arrived, then
  // let the pipeline run dry before anything touches the registers.
  task automatic wait_idle();
    while (angle_queue.size() != 0 || in_valid || duty_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleTicks) @(negedge clk);
  endtask

  // Write both registers back to back; only ever called with the block idle.
  task automatic write_settings(input logic [15:0] period_val,
                                input logic [15:0] amp_val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= RegPeriod;
    cfg_data  <= period_val;
    @(posedge clk);
    cfg_index <= RegAmplitude;
    cfg_data  <= amp_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_period = period_val;
    want_amp    = amp_val[14:0];
    @(negedge clk);
  endtask

  // Mostly rotating-angle ramps of random start and step, some lone angles.
  task automatic queue_angles(input int count);
    int         left;
    int         run;
    logic [7:0] a;
    logic [7:0] step;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) < 7) begin
        run  = $urandom_range(32, 8);
        a    = 8'($urandom);
        step = 8'($urandom_range(8, 1));
        if ($urandom_range(1) == 1) begin
          step = -step;
        end
        for (int k = 0; k < run && left > 0; k++) begin
          angle_queue.push_back(a);
          a = a + step;
          left--;
        end
      end else begin
        angle_queue.push_back(8'($urandom));
        left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed angles around the sector boundaries and
  // special settings, then random phases over a sweep of register values.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] boundary_angles [16];
    boundary_angles = '{8'd0, 8'd255, 8'd64, 8'd128, 8'd192, 8'd32, 8'd96, 8'd160,
                        8'd224, 8'd21, 8'd43, 8'd85, 8'd171, 8'd213, 8'd1, 8'd127};
    for (int i = 0; i < TblSize; i++) begin
      sin_lut[i] = rom_entry(i);
    end
    want_period = PeriodReset;
    want_amp    = AmpReset;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: table ends, quadrant points and sector edges
    foreach (boundary_angles[i]) begin
      angle_queue.push_back(boundary_angles[i]);
    end
    wait_idle();

    // zero amplitude: no valid sector, every phase at half the period
    write_settings(16'd4200, 16'd0);
    angle_queue.push_back(8'd0);
    angle_queue.push_back(8'd100);
    wait_idle();

    // full amplitude and period: overmodulation clamps; drop the top data bit
    write_settings(16'hFFFF, 16'hFFFF);
    angle_queue.push_back(8'd0);
    angle_queue.push_back(8'd43);
    angle_queue.push_back(8'd170);
    angle_queue.push_back(8'd200);
    wait_idle();

    // zero period: every compare must read zero
    write_settings(16'd0, 16'd20000);
    angle_queue.push_back(8'd30);
    angle_queue.push_back(8'd150);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       write_settings(PeriodReset, 16'(AmpReset));
        1:       write_settings(16'hFFFF, 16'h7FFF);
        2:       write_settings(16'd1, 16'($urandom));
        3:       write_settings(16'($urandom), 16'd0);
        5:       write_settings(16'd0, 16'($urandom));
        7:       write_settings(16'hFFFF, 16'($urandom));
        default: write_settings(16'($urandom), 16'($urandom));
      endcase
      // sender dense and receiver busy, then the reverse, then flat out
      if (ph < 3) begin
        send_gap = 17;
        recv_gap = 55;
      end else if (ph < 6) begin
        send_gap = 55;
        recv_gap = 17;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      // hold the result side off while angles keep coming, so the queue fills
      if (ph == 1 || ph == 4) begin
        hold_req++;
      end
      queue_angles(PhaseItems);
      // pause the sender until every result so far has come back
      wait_idle();
      queue_angles(PhaseItems);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb_space_vector_pwm_duty_top OK");
    end else begin
      $display("tb_space_vector_pwm_duty_top NOT OK");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run of this sequence.
  initial begin
    #400000;
    $display("tb_space_vector_pwm_duty_top NOT OK");
    $finish;
  end

endmodule
